// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros, clocked on i_clk with synchronous active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/rlbe_pkg.sv =====
package rlbe_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 64;
    localparam int CNT_W  = 4;

    // literal block header: top bit set, low bits carry the count
    localparam logic [BYTE_W-1:0] HDR_BASE = 8'h80;

    // one encoded byte offered to the packer
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_emit;

endpackage

// ===== rtl/core/rlbe_byte_if.sv =====
interface rlbe_byte_if import rlbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

// ===== rtl/core/rlbe_word_if.sv =====
interface rlbe_word_if import rlbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic [CNT_W-1:0]  out_bytes;
    logic              burst_end;

    modport source (output valid, out_word, out_bytes, burst_end, input ready);
    modport sink   (input valid, out_word, out_bytes, burst_end, output ready);
endinterface

// ===== rtl/core/rlbe_ram.sv =====
module rlbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/rlbe_pack.sv =====
module rlbe_pack import rlbe_pkg::*; #(
    parameter int OUT_LANES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_emit              i_emit,
    output logic               o_take,
    rlbe_word_if.source        o_out
);
    logic [CNT_W-1:0]  r_acc_n;
    logic [BYTE_W-1:0] r_lane [OUT_LANES];
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_word;
    logic [CNT_W-1:0]  r_out_bytes;
    logic              r_out_end;

    logic              w_done;
    logic              w_can_push;
    logic              w_push;
    logic [WORD_W-1:0] w_word;

    assign w_done     = i_emit.last || (r_acc_n == CNT_W'(OUT_LANES - 1));
    assign w_can_push = !r_out_vld || o_out.ready;
    assign o_take     = i_emit.vld && (!w_done || w_can_push);
    assign w_push     = o_take && w_done;

    // word as it stands with the offered byte in the next free lane
    always_comb begin
        w_word = '0;
        for (int k = 0; k < OUT_LANES; k++) begin
            if (CNT_W'(k) < r_acc_n) begin
                w_word[BYTE_W*k +: BYTE_W] = r_lane[k];
            end else if (CNT_W'(k) == r_acc_n) begin
                w_word[BYTE_W*k +: BYTE_W] = i_emit.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_n   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_acc_n <= w_done ? '0 : r_acc_n + 1'b1;
            end
            if (w_push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < OUT_LANES; k++) begin
            if (o_take && !w_done && CNT_W'(k) == r_acc_n) begin
                r_lane[k] <= i_emit.data;
            end
        end
        if (w_push) begin
            r_out_word  <= w_word;
            r_out_bytes <= r_acc_n + 1'b1;
            r_out_end   <= i_emit.last;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_word  = r_out_word;
    assign o_out.out_bytes = r_out_bytes;
    assign o_out.burst_end = r_out_end;
endmodule

// ===== rtl/core/run_length_byte_encoder_top.sv =====
// Flow: an input byte is taken only while the sequencer is idle; its B encoded bytes (B = 0
//   for most literals, at most 129) then leave one per cycle while the packer takes them.
//   The single byte emitter walks run codes, headers and the literal store one byte a cycle,
//   stalling when the packer does not take, and the next input byte waits until it is done.
// Reset: synchronous, active low; clears encoder state and handshakes. The literal store is not
//   cleared and needs no clearing pass.
module run_length_byte_encoder_top import rlbe_pkg::*; #(
    parameter int LITERAL_LIMIT = 127,
    parameter int RUN_LIMIT     = 128,
    parameter int OUT_LANES     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlbe_byte_if.sink    i_byte_if,
    rlbe_word_if.source  o_word_if
);
    localparam int FILL_W = $clog2(LITERAL_LIMIT + 1);
    localparam int ADDR_W = (LITERAL_LIMIT > 1) ? $clog2(LITERAL_LIMIT) : 1;
    localparam int RUN_W  = $clog2(RUN_LIMIT + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // ready for the next input transaction
    localparam logic [2:0] S_HDR  = 3'd1;  // literal header byte
    localparam logic [2:0] S_LIT  = 3'd2;  // literal bytes read back from the store
    localparam logic [2:0] S_RUN0 = 3'd3;  // run count byte
    localparam logic [2:0] S_RUN1 = 3'd4;  // run value byte

    // encoder state
    logic [FILL_W-1:0] r_fill,    n_fill;
    logic [BYTE_W-1:0] r_last,    n_last;
    logic              r_lvld,    n_lvld;
    logic              r_run_act, n_run_act;
    logic [RUN_W-1:0]  r_extra,   n_extra;

    // sequencer and emission plan for the current transaction
    logic [2:0]        r_state,    n_state;
    logic              r_pend_run, n_pend_run;  // run still to go out
    logic              r_pend_flb, n_pend_flb;  // literal flush after the run
    logic [RUN_W-1:0]  r_run_cnt,  n_run_cnt;
    logic [BYTE_W-1:0] r_run_byte, n_run_byte;
    logic [FILL_W-1:0] r_fl_n,     n_fl_n;
    logic [FILL_W-1:0] r_idx,      n_idx;

    // step decision, computed in the accept cycle
    logic              w_accept;
    logic              w_eq;
    logic              w_app;       // byte enters the literal store
    logic              w_fla;       // flush the store before anything else
    logic              w_run;       // a run goes out
    logic              w_flb;       // flush the store after the run
    logic [RUN_W-1:0]  w_run_cnt;
    logic [BYTE_W-1:0] w_run_byte;
    logic [FILL_W-1:0] w_fl_n;
    logic [FILL_W-1:0] w_f1;
    logic [FILL_W-1:0] p_fill;
    logic [BYTE_W-1:0] p_last;
    logic              p_lvld;
    logic              p_run_act;
    logic [RUN_W-1:0]  p_extra;

    // emission
    t_emit             w_emit;
    logic              w_take;
    logic              w_more;
    logic [FILL_W-1:0] w_idx_inc;
    logic              w_lit_end;
    logic [2:0]        w_seg_state;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [BYTE_W-1:0] w_rdata;

    assign i_byte_if.ready = (r_state == S_IDLE);
    assign w_accept        = i_byte_if.valid && i_byte_if.ready;
    assign w_eq            = (i_byte_if.data_byte == r_last);

    // Decide what this byte does. The result is at most one flush, one run and one flush,
    // in that order, and never both flushes.
    always_comb begin
        p_fill     = r_fill;
        p_last     = r_last;
        p_lvld     = r_lvld;
        p_run_act  = r_run_act;
        p_extra    = r_extra;
        w_app      = 1'b0;
        w_fla      = 1'b0;
        w_run      = 1'b0;
        w_flb      = 1'b0;
        w_run_cnt  = r_extra;
        w_run_byte = r_last;
        w_fl_n     = r_fill;
        w_f1       = r_fill + 1'b1;

        if (r_run_act) begin
            if (w_eq && (r_extra < RUN_W'(RUN_LIMIT))) begin
                p_extra = r_extra + 1'b1;
            end else begin
                // run closes; this byte starts fresh as a literal
                w_run     = 1'b1;
                w_app     = 1'b1;
                p_run_act = 1'b0;
                p_extra   = '0;
            end
        end else if (r_lvld && w_eq) begin
            // a single stored byte stays put; it is a copy of the run byte
            if (r_fill > FILL_W'(1)) begin
                w_fla  = 1'b1;
                p_fill = '0;
            end
            p_run_act = 1'b1;
            p_extra   = '0;
        end else begin
            w_app = 1'b1;
        end

        if (w_app) begin
            p_last = i_byte_if.data_byte;
            p_lvld = 1'b1;
            if (w_f1 >= FILL_W'(LITERAL_LIMIT)) begin
                w_flb  = 1'b1;
                w_fl_n = w_f1;
                p_fill = '0;
            end else begin
                p_fill = w_f1;
            end
        end

        // end of stream: drain what is pending, then back to reset values
        if (i_byte_if.final_byte) begin
            if (p_run_act) begin
                w_run      = 1'b1;
                w_run_cnt  = p_extra;
                w_run_byte = p_last;
            end
            if (p_fill != '0) begin
                w_flb  = 1'b1;
                w_fl_n = p_fill;
            end
            p_fill    = '0;
            p_last    = '0;
            p_lvld    = 1'b0;
            p_run_act = 1'b0;
            p_extra   = '0;
        end
    end

    // Byte emitter: one encoded byte per cycle toward the packer, while the packer takes it.
    assign w_more    = r_pend_run || r_pend_flb;
    assign w_idx_inc = r_idx + 1'b1;
    assign w_lit_end = (w_idx_inc == r_fl_n);

    always_comb begin
        w_emit = '0;
        case (r_state)
            S_HDR: begin
                w_emit.vld  = 1'b1;
                w_emit.data = HDR_BASE | BYTE_W'(r_fl_n);
            end
            S_LIT: begin
                w_emit.vld  = 1'b1;
                w_emit.last = w_lit_end && !w_more;
                w_emit.data = w_rdata;
            end
            S_RUN0: begin
                w_emit.vld  = 1'b1;
                w_emit.data = BYTE_W'(r_run_cnt);
            end
            S_RUN1: begin
                w_emit.vld  = 1'b1;
                w_emit.last = !w_more;
                w_emit.data = r_run_byte;
            end
            default: begin
                w_emit = '0;
            end
        endcase
    end

    // segment that follows the current one
    always_comb begin
        if (r_pend_run) begin
            w_seg_state = S_RUN0;
        end else if (r_pend_flb) begin
            w_seg_state = S_HDR;
        end else begin
            w_seg_state = S_IDLE;
        end
    end

    // store read runs one ahead of the byte being emitted
    assign w_re    = w_take && ((r_state == S_HDR) || ((r_state == S_LIT) && !w_lit_end));
    assign w_raddr = (r_state == S_HDR) ? '0 : w_idx_inc[ADDR_W-1:0];

    always_comb begin
        n_fill     = r_fill;
        n_last     = r_last;
        n_lvld     = r_lvld;
        n_run_act  = r_run_act;
        n_extra    = r_extra;
        n_state    = r_state;
        n_pend_run = r_pend_run;
        n_pend_flb = r_pend_flb;
        n_run_cnt  = r_run_cnt;
        n_run_byte = r_run_byte;
        n_fl_n     = r_fl_n;
        n_idx      = r_idx;

        if (w_accept) begin
            n_fill     = p_fill;
            n_last     = p_last;
            n_lvld     = p_lvld;
            n_run_act  = p_run_act;
            n_extra    = p_extra;
            n_run_cnt  = w_run_cnt;
            n_run_byte = w_run_byte;
            n_fl_n     = w_fl_n;
            n_pend_run = w_run;
            n_pend_flb = w_flb;
            if (w_fla) begin
                n_state = S_HDR;
            end else if (w_run) begin
                n_state    = S_RUN0;
                n_pend_run = 1'b0;
            end else if (w_flb) begin
                n_state    = S_HDR;
                n_pend_flb = 1'b0;
            end else begin
                n_state = S_IDLE;
            end
        end else if (w_take) begin
            case (r_state)
                S_HDR: begin
                    n_idx   = '0;
                    n_state = S_LIT;
                end
                S_LIT: begin
                    if (w_lit_end) begin
                        n_state = w_seg_state;
                        if (r_pend_run) begin
                            n_pend_run = 1'b0;
                        end else begin
                            n_pend_flb = 1'b0;
                        end
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
                S_RUN0: begin
                    n_state = S_RUN1;
                end
                S_RUN1: begin
                    n_state = w_seg_state;
                    if (r_pend_run) begin
                        n_pend_run = 1'b0;
                    end else begin
                        n_pend_flb = 1'b0;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_last     <= '0;
            r_lvld     <= 1'b0;
            r_run_act  <= 1'b0;
            r_extra    <= '0;
            r_state    <= S_IDLE;
            r_pend_run <= 1'b0;
            r_pend_flb <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_last     <= n_last;
            r_lvld     <= n_lvld;
            r_run_act  <= n_run_act;
            r_extra    <= n_extra;
            r_state    <= n_state;
            r_pend_run <= n_pend_run;
            r_pend_flb <= n_pend_flb;
        end
    end

    // plan payload, only meaningful while the sequencer is busy
    always_ff @(posedge i_clk) begin
        r_run_cnt  <= n_run_cnt;
        r_run_byte <= n_run_byte;
        r_fl_n     <= n_fl_n;
        r_idx      <= n_idx;
    end

    // literal store: written at accept, read back during a flush
    rlbe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LITERAL_LIMIT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_app),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_byte_if.data_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // packs emitted bytes into output words, with its own output register
    rlbe_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .o_take  (w_take),
        .o_out   (o_word_if)
    );
endmodule

// ===== rtl/core/rlbe_checker.sv =====
`include "assert_macros.svh"

module rlbe_checker import rlbe_pkg::*; #(
    parameter int OUT_LANES = 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [WORD_W-1:0] i_out_word,
    input logic [CNT_W-1:0]  i_out_bytes,
    input logic              i_burst_end
);
    `ASSERT_IMPL(a_bytes_range, i_out_valid, (i_out_bytes != '0) && (i_out_bytes <= CNT_W'(OUT_LANES)))
    `ASSERT_IMPL(a_upper_zero, i_out_valid, (i_out_word >> {i_out_bytes, 3'b000}) == '0)
    `ASSERT_IMPL(a_busy_mid_burst, i_out_valid && !i_burst_end, !i_in_ready)
    `ASSERT_NEXT(a_hold_stall, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word) && $stable(i_out_bytes) && $stable(i_burst_end))

    // input valid is observed for completeness of the port view
    logic w_in_seen;
    assign w_in_seen = i_in_valid && i_in_ready;
    `ASSERT_IMPL(a_no_take_mid_burst, w_in_seen, !(i_out_valid && !i_burst_end))
endmodule

bind run_length_byte_encoder_top rlbe_checker #(
    .OUT_LANES (OUT_LANES)
) u_rlbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte_if.valid),
    .i_in_ready  (i_byte_if.ready),
    .i_out_valid (o_word_if.valid),
    .i_out_ready (o_word_if.ready),
    .i_out_word  (o_word_if.out_word),
    .i_out_bytes (o_word_if.out_bytes),
    .i_burst_end (o_word_if.burst_end)
);

// ===== dv/tb_run_length_byte_encoder_top.sv =====
`timescale 1ns / 100ps

module tb_run_length_byte_encoder_top;
    import rlbe_pkg::*;

    localparam int LITERAL_LIMIT = 127;
    localparam int RUN_LIMIT     = 128;
    localparam int OUT_LANES     = 8;
    // longest stretch without any transaction before the run is declared hung
    localparam int STUCK_LIMIT   = 4000;
    // deliberate receiver hold-off, long enough to back the encoder up into its input
    localparam int HOLD_CYCLES   = 300;
    // settle time after the last expected word, covers a full literal flush
    localparam int DRAIN_CYCLES  = 200;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              fin;
    } raw_byte_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  nbytes;
        logic              last;
    } code_word_t;

    logic i_clk;
    logic i_rst_n;

    rlbe_byte_if byte_if ();
    rlbe_word_if word_if ();

    run_length_byte_encoder_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (byte_if),
        .o_word_if (word_if)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expectation stores
    raw_byte_t   raw_bytes_q[$];
    code_word_t  expected_words[$];
    logic [7:0]  emitted[$];

    // shadow copy of the encoder state
    logic [7:0]  lit_store [0:LITERAL_LIMIT-1];
    int unsigned lit_fill;
    logic [7:0]  prev_byte;
    bit          prev_valid;
    bit          in_run;
    int unsigned run_extra;

    // idle knobs, percent of cycles, set per phase by the sequencer
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    // hold-off request: the receiver starts a hold whenever the token moves
    int          hold_token;
    int          hold_seen;
    int          hold_left;

    bit          byte_taken;
    raw_byte_t   next_byte;
    code_word_t  want;
    int          stuck_cycles;
    int          n_errors;
    int          n_bytes_in;
    int          n_streams;
    int          n_words_out;

    // ------------------------------------------------------------------
    // Encoder prediction
    // ------------------------------------------------------------------

    // literal block: header 128 + count, then the stored bytes in order
    task automatic flush_literal_block();
        emitted.push_back(HDR_BASE + 8'(lit_fill));
        for (int i = 0; i < lit_fill; i++)
            emitted.push_back(lit_store[i]);
        lit_fill = 0;
    endtask

    // run code: extra-copy count, then the repeated byte
    task automatic emit_run_code();
        emitted.push_back(8'(run_extra));
        emitted.push_back(prev_byte);
        in_run    = 0;
        run_extra = 0;
    endtask

    task automatic store_literal(input logic [7:0] c);
        if (lit_fill < LITERAL_LIMIT) begin
            lit_store[lit_fill] = c;
            lit_fill++;
        end
        prev_byte  = c;
        prev_valid = 1;
        if (lit_fill >= LITERAL_LIMIT)
            flush_literal_block();
    endtask

    // one raw byte in, packed code words appended to expected_words
    task automatic encode_byte(input logic [7:0] c, input logic fin);
        code_word_t  cw;
        int unsigned n;
        emitted.delete();

        if (in_run) begin
            if (c == prev_byte && run_extra < RUN_LIMIT) begin
                run_extra++;
            end else begin
                emit_run_code();
                store_literal(c);
            end
        end else if (prev_valid && c == prev_byte) begin
            // a single stored byte stays put; it already holds a copy of the run byte
            if (lit_fill > 1)
                flush_literal_block();
            in_run    = 1;
            run_extra = 0;
        end else begin
            store_literal(c);
        end

        if (fin) begin
            if (in_run)
                emit_run_code();
            if (lit_fill > 0)
                flush_literal_block();
            lit_fill   = 0;
            prev_byte  = '0;
            prev_valid = 0;
            in_run     = 0;
            run_extra  = 0;
        end

        for (int pos = 0; pos < emitted.size(); pos += OUT_LANES) begin
            n = emitted.size() - pos;
            if (n > OUT_LANES)
                n = OUT_LANES;
            cw.word = '0;
            for (int k = 0; k < n; k++)
                cw.word[8*k +: 8] = emitted[pos + k];
            cw.nbytes = CNT_W'(n);
            cw.last   = (pos + n >= emitted.size());
            expected_words.push_back(cw);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: holds each byte until taken, random gaps between bytes
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid      <= 1'b0;
            byte_if.data_byte  <= '0;
            byte_if.final_byte <= 1'b0;
        end else if (!byte_if.valid || byte_taken) begin
            if (raw_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_byte = raw_bytes_q.pop_front();
                byte_if.valid      <= 1'b1;
                byte_if.data_byte  <= next_byte.data;
                byte_if.final_byte <= next_byte.fin;
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            word_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_seen != hold_token) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            word_if.ready <= 1'b0;
        end else begin
            word_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every input transaction, check every output
    // transaction against the oldest expectation, watch for a hang
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        byte_taken <= byte_if.valid && byte_if.ready;

        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            n_bytes_in++;
            if (byte_if.final_byte)
                n_streams++;
            encode_byte(byte_if.data_byte, byte_if.final_byte);
        end

        if (i_rst_n && word_if.valid && word_if.ready) begin
            n_words_out++;
            if (expected_words.size() == 0) begin
                $error("unexpected transaction: out_word %h out_bytes %0d burst_end %b",
                       word_if.out_word, word_if.out_bytes, word_if.burst_end);
                n_errors++;
            end else begin
                want = expected_words.pop_front();
                if (word_if.out_word !== want.word) begin
                    $error("out_word expected %h actual %h", want.word, word_if.out_word);
                    n_errors++;
                end
                if (word_if.out_bytes !== want.nbytes) begin
                    $error("out_bytes expected %0d actual %0d", want.nbytes, word_if.out_bytes);
                    n_errors++;
                end
                if (word_if.burst_end !== want.last) begin
                    $error("burst_end expected %b actual %b", want.last, word_if.burst_end);
                    n_errors++;
                end
            end
        end

        if ((byte_if.valid && byte_if.ready) || (word_if.valid && word_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;

        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d words still expected",
                     STUCK_LIMIT, expected_words.size());
            $display("tb_run_length_byte_encoder_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic fin);
        raw_byte_t r;
        r.data = b;
        r.fin  = fin;
        raw_bytes_q.push_back(r);
    endtask

    // Mostly well-formed streams: runs and literal bursts with random content,
    // stream ends sprinkled in, plus some noise bytes with a random final flag.
    task automatic queue_random_streams(input int n_items);
        int         left;
        int         seg_len;
        int         kind;
        logic [7:0] b;
        left = n_items;
        b    = $urandom;
        while (left > 0) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                seg_len = $urandom_range(2, 9);
                b = $urandom;
                repeat (seg_len) queue_byte(b, 1'b0);
            end else if (kind < 9) begin
                seg_len = $urandom_range(1, 8);
                repeat (seg_len) begin
                    b = b + 8'($urandom_range(1, 255));
                    queue_byte(b, 1'b0);
                end
            end else begin
                seg_len = 1;
                b = $urandom;
                queue_byte(b, 1'($urandom_range(1)));
            end
            left -= seg_len;
            if ($urandom_range(2) == 0)
                raw_bytes_q[raw_bytes_q.size() - 1].fin = 1'b1;
        end
        raw_bytes_q[raw_bytes_q.size() - 1].fin = 1'b1;
    endtask

    // run past its limit: the copy after the limit closes it and becomes a literal
    task automatic queue_long_run();
        logic [7:0] b;
        b = $urandom;
        repeat (RUN_LIMIT + 4) queue_byte(b, 1'b0);
        queue_byte(b + 8'd1, 1'b1);
    endtask

    // no two neighbors equal, so the literal store fills and flushes on its own
    task automatic queue_long_literal();
        logic [7:0] b;
        b = $urandom;
        repeat (LITERAL_LIMIT + 5) begin
            b = b + 8'($urandom_range(1, 255));
            queue_byte(b, 1'b0);
        end
        queue_byte(b + 8'd1, 1'b1);
    endtask

    // until every byte is taken and every expected word has come out
    task automatic wait_drained();
        while (raw_bytes_q.size() != 0 || byte_if.valid || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        byte_if.final_byte = 1'b0;
        word_if.ready      = 1'b0;
        byte_taken         = 1'b0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        hold_token         = 0;
        hold_seen          = 0;
        hold_left          = 0;
        stuck_cycles       = 0;
        n_errors           = 0;
        n_bytes_in         = 0;
        n_streams          = 0;
        n_words_out        = 0;
        lit_fill           = 0;
        prev_byte          = '0;
        prev_valid         = 0;
        in_run             = 0;
        run_extra          = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: byte extremes as one-byte streams; a zero byte right after
        // reset must not count as a repeat of the cleared previous byte.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        // plain literals only
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b1);
        // run with a single stored byte: store kept, run code then literal block
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        // two stored bytes get flushed before the run starts
        queue_byte(8'hA1, 1'b0);
        queue_byte(8'hB2, 1'b0);
        queue_byte(8'hB2, 1'b0);
        queue_byte(8'hB2, 1'b1);
        // run closed by a different byte, final on a new literal
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b1);
        // alternating bit patterns, repeat on the final byte
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'hA5, 1'b1);
        // final on a byte that extends an active run
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'h3C, 1'b1);
        wait_drained();

        // Phase 1: sender idles a little, receiver a lot
        tx_idle_pct = 22;
        rx_idle_pct = 88;
        queue_long_run();
        queue_random_streams(37);
        wait_drained();

        // Phase 2: the other way round
        tx_idle_pct = 88;
        rx_idle_pct = 22;
        queue_long_literal();
        queue_random_streams(37);
        wait_drained();

        // Phase 3: no idling, but open with a long receiver hold-off while the
        // sender keeps offering, so the encoder backs up and stalls its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_token  = hold_token + 1;
        queue_random_streams(40);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            n_errors++;
        end

        $display("Encoded %0d input bytes in %0d streams; checked %0d output words.",
                 n_bytes_in, n_streams, n_words_out);
        $display("Covered run and literal limits, three idle mixes and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("tb_run_length_byte_encoder_top OK");
        end else begin
            $display("tb_run_length_byte_encoder_top NOT OK");
        end
        $finish;
    end

endmodule
